// File: hw/rtl/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
// Used by the front end, the queue, the back end, the divider and the checker.
package pse_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Value given for a missing operand and after a fatal error
  localparam logic [31:0] VALUE_ERR = 32'hFFFF_FFFF;

  // Queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Bit-serial divider
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_BADCHAR = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP2,
    S_LHS,
    S_CALC,
    S_DIVW,
    S_PUSH,
    S_FIN,
    S_EMIT
  } state_e;

  // Classified character as it travels through the queue
  typedef struct packed {
    op_e        op;
    logic [3:0] digit;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/pse_front.sv
// Front end: takes expression characters and classifies them into operations.
// Depends on pse_pkg; feeds pse_queue.
module pse_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    ch_i,
  input  logic          last_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output pse_pkg::item_t q_item_o
);
  import pse_pkg::*;

  logic [7:0] ch_off;

  // Stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign ch_off = ch_i - CH_ZERO;

  // Classify the character
  always_comb begin
    q_item_o.digit = ch_off[3:0];
    q_item_o.last  = last_i;
    priority if (ch_i >= CH_ZERO && ch_i <= CH_NINE) begin
      q_item_o.op = OP_DIGIT;
    end else if (ch_i == CH_PLUS) begin
      q_item_o.op = OP_ADD;
    end else if (ch_i == CH_MINUS) begin
      q_item_o.op = OP_SUB;
    end else if (ch_i == CH_STAR) begin
      q_item_o.op = OP_MUL;
    end else if (ch_i == CH_SLASH) begin
      q_item_o.op = OP_DIV;
    end else begin
      q_item_o.op = OP_BAD;
    end
  end

endmodule

// File: hw/rtl/pse_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on pse_pkg.
module pse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pse_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output pse_pkg::item_t item_o,
  output logic           empty_o
);
  import pse_pkg::*;

  item_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/pse_divider.sv
// Bit-serial signed divider, truncating, one quotient bit per cycle.
// Depends on pse_pkg; used by pse_back.
module pse_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::div_req_t req_i,
  output pse_pkg::div_rsp_t rsp_o
);
  import pse_pkg::*;

  logic [32:0]       rem_q;
  logic [31:0]       quo_q;
  logic [31:0]       dvs_q;
  logic              neg_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;
  logic [31:0]       a_abs, b_abs;

  // Magnitudes; the most negative value maps to 2^31 unsigned
  assign a_abs = req_i.dividend[31] ? (~req_i.dividend + 32'd1) : req_i.dividend;
  assign b_abs = req_i.divisor[31]  ? (~req_i.divisor + 32'd1)  : req_i.divisor;

  // One restoring step
  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 32'd1) : quo_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= a_abs;
      dvs_q <= b_abs;
      neg_q <= req_i.dividend[31] ^ req_i.divisor[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/pse_back.sv
// Back end: operand stack memory and the sequencer that executes items.
// Depends on pse_pkg; drives pse_divider and the output register.
module pse_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::item_t    q_item_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output pse_pkg::div_req_t div_req_o,
  input  pse_pkg::div_rsp_t div_rsp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       value_o,
  output logic [2:0]        status_o
);
  import pse_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   stack_mem [STACK_DEPTH];
  logic [31:0]   rd_data_q;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  status_e       status_q, status_d;
  logic          aborted_q, aborted_d;
  logic          popv_q, popv_d;
  item_t         item_q;
  logic [31:0]   rhs_q, rhs_d;
  logic [31:0]   lhs_q, lhs_d;
  logic [31:0]   res_q, res_d;
  logic [31:0]   popped;
  logic          push_req, pop_req;
  logic [31:0]   push_val;
  logic          wr_en, rd_en;
  logic          out_free, out_load;
  logic [31:0]   out_value_d, out_value_q;
  status_e       out_status_d, out_status_q;
  logic          out_valid_q;

  function automatic status_e note_status(status_e cur, status_e s);
    return (cur == ST_OK) ? s : cur;
  endfunction

  assign count_m1 = count_q - 1'b1;
  assign popped   = popv_q ? rd_data_q : VALUE_ERR;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  assign div_req_o.start    = (state_q == S_CALC) && (item_q.op == OP_DIV) && (rhs_q != '0);
  assign div_req_o.dividend = lhs_q;
  assign div_req_o.divisor  = rhs_q;

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  // Sequencer: next state, stack requests, status
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    status_d     = status_q;
    aborted_d    = aborted_q;
    popv_d       = popv_q;
    rhs_d        = rhs_q;
    lhs_d        = lhs_q;
    res_d        = res_q;
    push_req     = 1'b0;
    pop_req      = 1'b0;
    push_val     = res_q;
    out_load     = 1'b0;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (aborted_q) begin
            state_d = q_item_i.last ? S_EMIT : S_IDLE;
          end else if (q_item_i.op == OP_DIGIT) begin
            push_req = 1'b1;
            push_val = {28'd0, q_item_i.digit};
            state_d  = q_item_i.last ? S_FIN : S_IDLE;
          end else begin
            pop_req = 1'b1;
            state_d = S_POP2;
          end
        end
      end
      S_POP2: begin
        rhs_d   = popped;
        pop_req = 1'b1;
        state_d = S_LHS;
      end
      S_LHS: begin
        lhs_d   = popped;
        state_d = S_CALC;
      end
      S_CALC: begin
        unique case (item_q.op)
          OP_ADD: begin
            res_d   = lhs_q + rhs_q;
            state_d = S_PUSH;
          end
          OP_SUB: begin
            res_d   = lhs_q - rhs_q;
            state_d = S_PUSH;
          end
          OP_MUL: begin
            res_d   = lhs_q * rhs_q;
            state_d = S_PUSH;
          end
          OP_DIV: begin
            if (rhs_q == '0) begin
              status_d  = note_status(status_q, ST_DIVZERO);
              aborted_d = 1'b1;
              state_d   = item_q.last ? S_FIN : S_IDLE;
            end else begin
              state_d = S_DIVW;
            end
          end
          default: begin
            status_d  = note_status(status_q, ST_BADCHAR);
            aborted_d = 1'b1;
            state_d   = item_q.last ? S_FIN : S_IDLE;
          end
        endcase
      end
      S_DIVW: begin
        if (div_rsp_i.done) begin
          res_d   = div_rsp_i.quotient;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        push_req = 1'b1;
        state_d  = item_q.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // pop the result unless the expression was abandoned
        pop_req = !aborted_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_value_d  = aborted_q ? VALUE_ERR : popped;
          out_status_d = status_q;
          count_d      = '0;
          status_d     = ST_OK;
          aborted_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Stack pointer handling for push and pop
    wr_en = 1'b0;
    rd_en = 1'b0;
    if (push_req) begin
      if (count_q == CW'(STACK_DEPTH)) begin
        status_d = note_status(status_d, ST_OVER);
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
      end
    end
    if (pop_req) begin
      if (count_q == '0) begin
        popv_d   = 1'b0;
        status_d = note_status(status_d, ST_UNDER);
      end else begin
        rd_en   = 1'b1;
        popv_d  = 1'b1;
        count_d = count_m1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      status_q    <= ST_OK;
      aborted_q   <= 1'b0;
      popv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      status_q  <= status_d;
      aborted_q <= aborted_d;
      popv_q    <= popv_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    rhs_q        <= rhs_d;
    lhs_q        <= lhs_d;
    res_q        <= res_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
  end

  // Operand stack memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[count_q[AW-1:0]] <= push_val;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[count_m1[AW-1:0]];
    end
  end

endmodule

// File: hw/rtl/postfix_stack_evaluator.sv
// Postfix evaluator: a character transfer enters a 4-entry queue, from which the back end
// takes it when idle. A digit is pushed; + - * pop two operands and push the result; / does
// the same through the 32-step divider. A bad character or divide by zero abandons the
// expression, and later items up to the final one are dropped; a final item pops the result.
// A stalled result holds the back end; the queue keeps taking characters until it fills.
// rst_ni clears control state asynchronously; stack contents stay undefined until pushed.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]  status_o
);
  import pse_pkg::*;

  item_t    fr_item, q_item;
  logic     q_push, q_full, q_pop, q_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [31:0] value;

  pse_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (fr_item)
  );

  pse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  pse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_item_i    (q_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value),
    .status_o    (status_o)
  );

  pse_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign value_o = signed'(value);

endmodule

// File: hw/rtl/pse_checker.sv
// Port-level checks for the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg and postfix_stack_evaluator.
module pse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [31:0] value_o,
  input logic [2:0]  status_o
);
  import pse_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value and status
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(status_o))
    else $error("stalled result changed");

  // A fatal first status always comes with the error value
  a_fatal_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DIVZERO || status_o == ST_BADCHAR)
      |-> value_o == signed'(VALUE_ERR))
    else $error("fatal status without error value");

  // The queue is empty right after reset, so input is taken at once
  a_reset_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for postfix_stack_evaluator: random and directed expressions,
// a scoreboard class that tracks the operand stack, random input gaps and random result stalls.
// Depends on pse_pkg for character codes, the error value and status codes.
module testbench;
  import pse_pkg::*;

  localparam int unsigned EVAL_DEPTH     = 64;
  localparam int unsigned TOTAL_CHARS    = 1850;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } eval_result_t;

  // Tracks the operand stack and queues the result of each finished expression
  class expression_scoreboard;
    logic [31:0]  operands [EVAL_DEPTH];
    int unsigned  stacked;
    status_e      first_err;
    bit           fatal;
    eval_result_t expected [$];
    int unsigned  fail_count;
    int unsigned  checked;

    function new();
      stacked    = 0;
      first_err  = ST_OK;
      fatal      = 1'b0;
      fail_count = 0;
      checked    = 0;
    endfunction

    function void record_status(status_e s);
      if (first_err == ST_OK) first_err = s;
    endfunction

    function void push_operand(logic [31:0] v);
      if (stacked >= EVAL_DEPTH) begin
        record_status(ST_OVER);
        return;
      end
      operands[stacked] = v;
      stacked++;
    endfunction

    function logic [31:0] pop_operand();
      if (stacked == 0) begin
        record_status(ST_UNDER);
        return VALUE_ERR;
      end
      stacked--;
      return operands[stacked];
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    // Apply one accepted character; a final one queues the expected result
    function void note_char(logic [7:0] c, logic fin);
      logic [31:0]  rhs;
      logic [31:0]  lhs;
      logic [31:0]  res;
      bit           keep;
      eval_result_t outcome;
      if (!fatal) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          push_operand(32'(c) - 32'(CH_ZERO));
        end else begin
          // operands are popped before the character is classified
          rhs  = pop_operand();
          lhs  = pop_operand();
          keep = 1'b1;
          res  = '0;
          case (c)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            CH_SLASH: begin
              if (rhs == '0) begin
                record_status(ST_DIVZERO);
                fatal = 1'b1;
                keep  = 1'b0;
              end else if (lhs == 32'h8000_0000 && rhs == VALUE_ERR) begin
                res = 32'h8000_0000;
              end else begin
                res = $signed(lhs) / $signed(rhs);
              end
            end
            default: begin
              record_status(ST_BADCHAR);
              fatal = 1'b1;
              keep  = 1'b0;
            end
          endcase
          if (keep) push_operand(res);
        end
      end
      if (fin) begin
        outcome.value  = fatal ? VALUE_ERR : pop_operand();
        outcome.status = first_err;
        expected.push_back(outcome);
        stacked   = 0;
        first_err = ST_OK;
        fatal     = 1'b0;
      end
    endfunction

    // Compare one result transfer with the oldest expected result
    function void check_result(logic [31:0] v, logic [2:0] s);
      eval_result_t want;
      checked++;
      if (expected.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result %0d unexpected: value %0d status %0d", checked, $signed(v), s);
        return;
      end
      want = expected.pop_front();
      if (v !== want.value || s !== want.status) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result %0d: value exp %0d got %0d, status exp %0d got %0d", checked,
                   $signed(want.value), $signed(v), want.status, s);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         ch_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] value_o;
  logic [2:0]         status_o;

  expression_scoreboard board = new();
  int unsigned chars_sent = 0;
  bit          sender_eager = 1'b0;

  postfix_stack_evaluator #(
    .STACK_DEPTH(EVAL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .status_o   (status_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // One character transfer; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ch_i       = c;
    last_i     = fin;
    do @(posedge clk_i); while (in_stall_o);
    board.note_char(c, fin);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] expr [$]);
    foreach (expr[i]) send_char(expr[i], i == expr.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] expr [$];
    foreach (s[i]) expr.push_back(s[i]);
    send_bytes(expr);
  endtask

  // Postfix expression with random digits and operators; optionally damaged
  task automatic send_random_expr(input int operands, input bit deep, input bit corrupt);
    logic [7:0] expr [$];
    int         depth;
    int         pushed;
    int         pos;
    depth  = 0;
    pushed = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (deep || depth < 2 || $urandom_range(0, 2) != 0)) begin
        expr.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        pushed++;
        depth++;
      end else begin
        expr.push_back(random_op());
        depth--;
      end
    end
    if (corrupt) begin
      pos = $urandom_range(0, expr.size() - 1);
      case ($urandom_range(0, 2))
        0: expr[pos] = 8'($urandom_range(0, 255));
        1: expr.insert(pos, random_op());
        default: if (expr.size() > 1) expr.delete(pos);
      endcase
    end
    send_bytes(expr);
  endtask

  task automatic send_noise();
    logic [7:0] expr [$];
    repeat ($urandom_range(1, 6)) expr.push_back(8'($urandom_range(0, 255)));
    send_bytes(expr);
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned pick;
    bit          paused;
    paused     = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    ch_i       = '0;
    last_i     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every operator, truncation, underflow, divide by zero, bad characters
    send_text("9");
    send_text("0");
    send_text("34+");
    send_text("97*");
    send_text("72/");
    send_text("07-3/");
    send_text("50/3+");
    send_text("+");
    send_text("1a2");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    // random expressions
    while (chars_sent < TOTAL_CHARS) begin
      sender_eager = ($urandom_range(0, 9) == 0);
      if (!paused && chars_sent >= TOTAL_CHARS / 2) begin
        paused = 1'b1;
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_random_expr($urandom_range(1, 10), 1'b0, 1'b0);
      end else if (pick < 80) begin
        send_random_expr($urandom_range(1, 10), 1'b0, 1'b1);
      end else if (pick < 85) begin
        // pushes up to and past the stack depth
        send_random_expr($urandom_range(EVAL_DEPTH - 2, EVAL_DEPTH + 6), 1'b1, 1'b0);
      end else if (pick < 89) begin
        // most negative value divided by minus one
        send_text("88*8*8*8*8*8*8*8*8*2*01-/");
      end else begin
        send_noise();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side stalls: free runs alternate with stalls, one long hold-off
  initial begin : result_sink
    int free_run;
    int hold_run;
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                             : $urandom_range(1, 12);
      out_stall_i = 1'b0;
      repeat (free_run) @(negedge clk_i);
      if (!held && board.checked >= 40) begin
        held     = 1'b1;
        hold_run = HOLD_CYCLES;
      end else begin
        hold_run = pick_gap();
      end
      if (hold_run > 0) begin
        out_stall_i = 1'b1;
        repeat (hold_run) @(negedge clk_i);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(value_o, status_o);
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
